[hdl/amd_pkg.sv]
`default_nettype none
package amd_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int SQ_STEPS     = 32;
  localparam int ATAN_LAT     = CORDIC_STEPS + 4;
  localparam int PIPE_DEPTH   = SQ_STEPS + ATAN_LAT + 5;

  localparam int AW    = 34;
  localparam int XW    = 43;
  localparam int ZW    = 35;
  localparam int ANG_W = 19;

  localparam longint PI_Q30_L = 64'sd3373259426;
  localparam logic signed [ZW-1:0] PI_Q30 = ZW'(PI_Q30_L);
  localparam logic signed [ZW-1:0] ROUND_Q30 = ZW'(8192);
  localparam logic signed [ANG_W-1:0] ANGLE_LIMIT = ANG_W'(205887);
  localparam logic signed [ANG_W-1:0] PI_Q16 = ANG_W'((PI_Q30_L + 8192) >>> 14);
  localparam logic [5:0] NORM_MSB = 6'd39;

  typedef struct packed {
    logic zero_y;
    logic neg_x;
  } atan_tag_t;

  typedef struct packed {
    logic signed [31:0] e0;
    logic signed [31:0] e3;
    logic signed [31:0] e4;
    logic signed [31:0] e5;
    logic signed [31:0] e6;
    logic signed [31:0] e7;
    logic signed [31:0] e8;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } side_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [30:0]        sx;
    logic [30:0]        sy;
    logic [30:0]        sz;
    logic               sing;
  } tail_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : 32'(v);
    return r;
  endfunction

  function automatic logic signed [ZW-1:0] arc_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      5'd0:  r = ZW'(843314856);
      5'd1:  r = ZW'(497837829);
      5'd2:  r = ZW'(263043836);
      5'd3:  r = ZW'(133525158);
      5'd4:  r = ZW'(67021686);
      5'd5:  r = ZW'(33543515);
      5'd6:  r = ZW'(16775850);
      5'd7:  r = ZW'(8388437);
      5'd8:  r = ZW'(4194282);
      5'd9:  r = ZW'(2097149);
      5'd10: r = ZW'(1048575);
      5'd11: r = ZW'(524287);
      5'd12: r = ZW'(262143);
      5'd13: r = ZW'(131071);
      5'd14: r = ZW'(65535);
      5'd15: r = ZW'(32767);
      5'd16: r = ZW'(16383);
      5'd17: r = ZW'(8191);
      5'd18: r = ZW'(4095);
      5'd19: r = ZW'(2047);
      5'd20: r = ZW'(1023);
      5'd21: r = ZW'(511);
      5'd22: r = ZW'(255);
      5'd23: r = ZW'(127);
      5'd24: r = ZW'(63);
      5'd25: r = ZW'(31);
      5'd26: r = ZW'(15);
      5'd27: r = ZW'(7);
      5'd28: r = ZW'(3);
      5'd29: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/affine_matrix_decompose_unit.sv]
`default_nettype none
// Channel   Handshake               Payload
// input     start / busy            r0c0_i .. r3c2_i
// result    done_o strobe           pos_*_o, angle_*_o, scale_*_o, singular_o
// config    cfg_valid_i/cfg_ready_o cfg_data_i (singular limit)
//
// A new matrix is taken every cycle; busy stays low.
// A result appears for each accepted beat, one per accepted beat.
// The 32-cell square root chain and the 24-cell CORDIC chains set the pipeline depth.
// Reset clears the valid line and sets the singular limit to one.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module affine_matrix_decompose_unit import amd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [31:0]      r0c0_i,
  input  logic signed [31:0]      r0c1_i,
  input  logic signed [31:0]      r0c2_i,
  input  logic signed [31:0]      r1c0_i,
  input  logic signed [31:0]      r1c1_i,
  input  logic signed [31:0]      r1c2_i,
  input  logic signed [31:0]      r2c0_i,
  input  logic signed [31:0]      r2c1_i,
  input  logic signed [31:0]      r2c2_i,
  input  logic signed [31:0]      r3c0_i,
  input  logic signed [31:0]      r3c1_i,
  input  logic signed [31:0]      r3c2_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [15:0]             cfg_data_i,
  output logic                    done_o,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic signed [31:0]      pos_z_o,
  output logic signed [ANG_W-1:0] angle_x_o,
  output logic signed [ANG_W-1:0] angle_y_o,
  output logic signed [ANG_W-1:0] angle_z_o,
  output logic [30:0]             scale_x_o,
  output logic [30:0]             scale_y_o,
  output logic [30:0]             scale_z_o,
  output logic                    singular_o
);

  logic [PIPE_DEPTH-1:0] vld_q;
  logic [15:0]           limit_q;
  logic                  accept;

  logic signed [31:0] e_q [12];
  logic [31:0]        m [9];
  logic [63:0]        prod_q [9];
  logic [63:0]        sum_q [4];
  side_t              side_q [SQ_STEPS+2];
  side_t              side_d;

  logic [63:0] rad_w  [4][SQ_STEPS+1];
  logic [32:0] rem_w  [4][SQ_STEPS+1];
  logic [31:0] root_w [4][SQ_STEPS+1];

  side_t                sd;
  logic                 sing_d;
  logic signed [AW-1:0] axy_q, axx_q, ayy_q, ayx_q, azy_q, azx_q;
  logic signed [AW-1:0] axy_d, axx_d, ayy_d, ayx_d;
  tail_t                tail_d;
  tail_t                tail_q [ATAN_LAT+1];

  logic signed [ANG_W-1:0] ang_x, ang_y, ang_z;
  tail_t                   tl;
  logic signed [ANG_W-1:0] angle_x_q, angle_y_q, angle_z_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      limit_q <= 16'd1;
    end else begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], accept};
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e_q[0]  <= r0c0_i;
    e_q[1]  <= r0c1_i;
    e_q[2]  <= r0c2_i;
    e_q[3]  <= r1c0_i;
    e_q[4]  <= r1c1_i;
    e_q[5]  <= r1c2_i;
    e_q[6]  <= r2c0_i;
    e_q[7]  <= r2c1_i;
    e_q[8]  <= r2c2_i;
    e_q[9]  <= r3c0_i;
    e_q[10] <= r3c1_i;
    e_q[11] <= r3c2_i;
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      m[k] = mag32(e_q[k]);
    end
    side_d.e0 = e_q[0];
    side_d.e3 = e_q[3];
    side_d.e4 = e_q[4];
    side_d.e5 = e_q[5];
    side_d.e6 = e_q[6];
    side_d.e7 = e_q[7];
    side_d.e8 = e_q[8];
    side_d.px = e_q[9];
    side_d.py = e_q[10];
    side_d.pz = e_q[11];
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 9; k++) begin
      prod_q[k] <= {32'd0, m[k]} * {32'd0, m[k]};
    end
    sum_q[0] <= prod_q[0] + prod_q[1] + prod_q[2];
    sum_q[1] <= prod_q[3] + prod_q[4] + prod_q[5];
    sum_q[2] <= prod_q[6] + prod_q[7] + prod_q[8];
    sum_q[3] <= prod_q[0] + prod_q[3];
    side_q[0] <= side_d;
    for (int k = 1; k < SQ_STEPS + 2; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_root
    assign rad_w[c][0]  = sum_q[c];
    assign rem_w[c][0]  = '0;
    assign root_w[c][0] = '0;
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_cell
      amd_sqrt_cell u_cell (
        .clk_i  (clk_i),
        .rad_i  (rad_w[c][j]),
        .rem_i  (rem_w[c][j]),
        .root_i (root_w[c][j]),
        .rad_o  (rad_w[c][j+1]),
        .rem_o  (rem_w[c][j+1]),
        .root_o (root_w[c][j+1])
      );
    end
  end

  always_comb begin
    sd     = side_q[SQ_STEPS+1];
    sing_d = root_w[3][SQ_STEPS] < {16'd0, limit_q};
    axy_d  = sing_d ? -AW'(sd.e5) : AW'(sd.e7);
    axx_d  = sing_d ? AW'(sd.e4) : AW'(sd.e8);
    ayy_d  = -AW'(sd.e6);
    ayx_d  = $signed({2'b00, root_w[3][SQ_STEPS]});
    tail_d.px = sd.px;
    tail_d.py = sd.py;
    tail_d.pz = sd.pz;
    tail_d.sx = root_w[0][SQ_STEPS][31] ? 31'h7FFF_FFFF : root_w[0][SQ_STEPS][30:0];
    tail_d.sy = root_w[1][SQ_STEPS][31] ? 31'h7FFF_FFFF : root_w[1][SQ_STEPS][30:0];
    tail_d.sz = root_w[2][SQ_STEPS][31] ? 31'h7FFF_FFFF : root_w[2][SQ_STEPS][30:0];
    tail_d.sing = sing_d;
  end

  always_ff @(posedge clk_i) begin
    axy_q <= axy_d;
    axx_q <= axx_d;
    ayy_q <= ayy_d;
    ayx_q <= ayx_d;
    azy_q <= AW'(sd.e3);
    azx_q <= AW'(sd.e0);
    tail_q[0] <= tail_d;
    for (int k = 1; k < ATAN_LAT + 1; k++) begin
      tail_q[k] <= tail_q[k-1];
    end
  end

  amd_atan2 u_atan_x (
    .clk_i   (clk_i),
    .y_i     (axy_q),
    .x_i     (axx_q),
    .angle_o (ang_x)
  );

  amd_atan2 u_atan_y (
    .clk_i   (clk_i),
    .y_i     (ayy_q),
    .x_i     (ayx_q),
    .angle_o (ang_y)
  );

  amd_atan2 u_atan_z (
    .clk_i   (clk_i),
    .y_i     (azy_q),
    .x_i     (azx_q),
    .angle_o (ang_z)
  );

  assign tl = tail_q[ATAN_LAT];

  always_ff @(posedge clk_i) begin
    pos_x_o    <= tl.px;
    pos_y_o    <= tl.py;
    pos_z_o    <= tl.pz;
    scale_x_o  <= tl.sx;
    scale_y_o  <= tl.sy;
    scale_z_o  <= tl.sz;
    singular_o <= tl.sing;
    angle_x_q  <= ang_x;
    angle_y_q  <= ang_y;
    angle_z_q  <= tl.sing ? '0 : ang_z;
  end

  assign angle_x_o = angle_x_q;
  assign angle_y_o = angle_y_q;
  assign angle_z_o = angle_z_q;
  assign done_o    = vld_q[PIPE_DEPTH-1];

`ifndef NO_ASSERTIONS
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result beat without an accepted input beat");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (angle_x_o <= ANGLE_LIMIT) && (angle_x_o >= -ANGLE_LIMIT) &&
               (angle_y_o <= ANGLE_LIMIT) && (angle_y_o >= -ANGLE_LIMIT) &&
               (angle_z_o <= ANGLE_LIMIT) && (angle_z_o >= -ANGLE_LIMIT))
    else $error("angle outside of the pi range");

  a_singular_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && singular_o) |-> (angle_z_o == '0))
    else $error("z angle not zero on a singular matrix");
`endif

endmodule
`default_nettype wire

[hdl/amd_sqrt_cell.sv]
`default_nettype none
module amd_sqrt_cell import amd_pkg::*; (
  input  logic        clk_i,
  input  logic [63:0] rad_i,
  input  logic [32:0] rem_i,
  input  logic [31:0] root_i,
  output logic [63:0] rad_o,
  output logic [32:0] rem_o,
  output logic [31:0] root_o
);

  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic [34:0] diff;
  logic [63:0] rad_d, rad_q;
  logic [32:0] rem_d, rem_q;
  logic [31:0] root_d, root_q;

  always_comb begin
    rem_sh = {rem_i, rad_i[63:62]};
    trial  = {1'b0, root_i, 2'b01};
    diff   = rem_sh - trial;
    rad_d  = {rad_i[61:0], 2'b00};
    if (rem_sh >= trial) begin
      rem_d  = diff[32:0];
      root_d = {root_i[30:0], 1'b1};
    end else begin
      rem_d  = rem_sh[32:0];
      root_d = {root_i[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

[hdl/amd_cordic_cell.sv]
`default_nettype none
module amd_cordic_cell import amd_pkg::*; (
  input  logic                 clk_i,
  input  logic [4:0]           step_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  atan_tag_t            tag_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output atan_tag_t            tag_o
);

  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] arc;
  logic signed [XW-1:0] x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  atan_tag_t            tag_q;

  always_comb begin
    dx  = y_i >>> step_i;
    dy  = x_i >>> step_i;
    arc = arc_q30(step_i);
    if (y_i > 0) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + arc;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - arc;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    tag_q <= tag_i;
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;
  assign tag_o = tag_q;

endmodule
`default_nettype wire

[hdl/amd_atan2.sv]
`default_nettype none
module amd_atan2 import amd_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [AW-1:0]    y_i,
  input  logic signed [AW-1:0]    x_i,
  output logic signed [ANG_W-1:0] angle_o
);

  logic signed [AW-1:0] x1_d, y1_d, x1_q, y1_q, x2_q, y2_q;
  logic signed [ZW-1:0] z1_d, z1_q, z2_q, z3_q;
  logic [AW-1:0]        ax, ay, m1_d, m1_q;
  atan_tag_t            tag1_d, tag1_q, tag2_q, tag3_q;
  logic [5:0]           msb, sh2_q;
  logic signed [XW-1:0] xe, ye, x3_q, y3_q;

  logic signed [XW-1:0] xw [CORDIC_STEPS+1];
  logic signed [XW-1:0] yw [CORDIC_STEPS+1];
  logic signed [ZW-1:0] zw [CORDIC_STEPS+1];
  atan_tag_t            tw [CORDIC_STEPS+1];

  logic signed [ZW-1:0]    zr, qf;
  logic signed [ANG_W-1:0] q_d, angle_q;

  // The left half plane is folded over by a turn of pi first.
  always_comb begin
    tag1_d.zero_y = (y_i == '0);
    tag1_d.neg_x  = x_i[AW-1];
    x1_d = tag1_d.neg_x ? -x_i : x_i;
    y1_d = tag1_d.neg_x ? -y_i : y_i;
    z1_d = '0;
    if (tag1_d.neg_x) begin
      z1_d = (y_i > 0) ? PI_Q30 : -PI_Q30;
    end
    ax   = x1_d[AW-1] ? AW'(-x1_d) : AW'(x1_d);
    ay   = y1_d[AW-1] ? AW'(-y1_d) : AW'(y1_d);
    m1_d = (ax > ay) ? ax : ay;
  end

  always_ff @(posedge clk_i) begin
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    z1_q   <= z1_d;
    m1_q   <= m1_d;
    tag1_q <= tag1_d;
  end

  always_comb begin
    msb = '0;
    for (int b = 0; b < AW; b++) begin
      if (m1_q[b]) begin
        msb = 6'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x2_q   <= x1_q;
    y2_q   <= y1_q;
    z2_q   <= z1_q;
    sh2_q  <= NORM_MSB - msb;
    tag2_q <= tag1_q;
  end

  always_comb begin
    xe = XW'(x2_q);
    ye = XW'(y2_q);
  end

  always_ff @(posedge clk_i) begin
    x3_q   <= xe <<< sh2_q;
    y3_q   <= ye <<< sh2_q;
    z3_q   <= z2_q;
    tag3_q <= tag2_q;
  end

  assign xw[0] = x3_q;
  assign yw[0] = y3_q;
  assign zw[0] = z3_q;
  assign tw[0] = tag3_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    amd_cordic_cell u_cell (
      .clk_i  (clk_i),
      .step_i (5'(i)),
      .x_i    (xw[i]),
      .y_i    (yw[i]),
      .z_i    (zw[i]),
      .tag_i  (tw[i]),
      .x_o    (xw[i+1]),
      .y_o    (yw[i+1]),
      .z_o    (zw[i+1]),
      .tag_o  (tw[i+1])
    );
  end

  always_comb begin
    zr = zw[CORDIC_STEPS] + ROUND_Q30;
    qf = zr >>> 14;
    if (tw[CORDIC_STEPS].zero_y) begin
      q_d = tw[CORDIC_STEPS].neg_x ? PI_Q16 : '0;
    end else if (qf > ANGLE_LIMIT) begin
      q_d = ANGLE_LIMIT;
    end else if (qf < -ANGLE_LIMIT) begin
      q_d = -ANGLE_LIMIT;
    end else begin
      q_d = ANG_W'(qf);
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= q_d;
  end

  assign angle_o = angle_q;

endmodule
`default_nettype wire

[tb/affine_matrix_decompose_unit_tb.sv]
`timescale 1ns / 1ps
module affine_matrix_decompose_unit_tb;
  import amd_pkg::*;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [ANG_W-1:0] ax, ay, az;
    logic [30:0] sx, sy, sz;
    logic sing;
  } pose_t;

  typedef logic signed [31:0] mat_t [12];

  localparam longint PI_L = 64'sd3373259426;
  localparam longint ALIM = 64'sd205887;

  longint arc_tab [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850,
    8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 7, 3, 1, 0, 0};

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint cordic_angle(longint y, longint x);
    longint z, q, dx, dy;
    longint unsigned m;
    z = 0;
    if (y == 0) return x < 0 ? floor_shift(PI_L + 8192, 14) : 0;
    if (x < 0) begin
      z = y > 0 ? PI_L : -PI_L;
      x = -x;
      y = -y;
    end
    m = abs64(x) > abs64(y) ? abs64(x) : abs64(y);
    while (m < (64'd1 << 39)) begin
      x *= 2;
      y *= 2;
      m <<= 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += arc_tab[i];
      end else begin
        x -= dx; y += dy; z -= arc_tab[i];
      end
    end
    q = floor_shift(z + 8192, 14);
    if (q > ALIM) q = ALIM;
    if (q < -ALIM) q = -ALIM;
    return q;
  endfunction

  function automatic logic [30:0] row_len(longint a, longint b, longint c);
    longint unsigned r;
    r = floor_root(abs64(a) * abs64(a) + abs64(b) * abs64(b) + abs64(c) * abs64(c));
    return r > 64'h7FFFFFFF ? 31'h7FFFFFFF : r[30:0];
  endfunction

  function automatic pose_t decompose(mat_t e, logic [15:0] lim);
    pose_t p;
    longint unsigned sy;
    sy = floor_root(abs64(e[0]) * abs64(e[0]) + abs64(e[3]) * abs64(e[3]));
    p.sing = sy < lim;
    if (!p.sing) begin
      p.ax = ANG_W'(cordic_angle(e[7], e[8]));
      p.az = ANG_W'(cordic_angle(e[3], e[0]));
    end else begin
      p.ax = ANG_W'(cordic_angle(-longint'(e[5]), e[4]));
      p.az = '0;
    end
    p.ay = ANG_W'(cordic_angle(-longint'(e[6]), longint'(sy)));
    p.px = e[9]; p.py = e[10]; p.pz = e[11];
    p.sx = row_len(e[0], e[1], e[2]);
    p.sy = row_len(e[3], e[4], e[5]);
    p.sz = row_len(e[6], e[7], e[8]);
    return p;
  endfunction

  class pose_scoreboard;
    pose_t pending[$];
    int errors;
    logic [15:0] limit;

    function void note_matrix(mat_t e);
      pending.push_back(decompose(e, limit));
    endfunction

    function void check_pose(pose_t got);
      pose_t w;
      if (pending.size() == 0) begin
        $error("unexpected result beat");
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.px !== w.px) begin $error("pos_x exp %0d got %0d", w.px, got.px); errors++; end
      if (got.py !== w.py) begin $error("pos_y exp %0d got %0d", w.py, got.py); errors++; end
      if (got.pz !== w.pz) begin $error("pos_z exp %0d got %0d", w.pz, got.pz); errors++; end
      if (got.ax !== w.ax) begin $error("angle_x exp %0d got %0d", w.ax, got.ax); errors++; end
      if (got.ay !== w.ay) begin $error("angle_y exp %0d got %0d", w.ay, got.ay); errors++; end
      if (got.az !== w.az) begin $error("angle_z exp %0d got %0d", w.az, got.az); errors++; end
      if (got.sx !== w.sx) begin $error("scale_x exp %0d got %0d", w.sx, got.sx); errors++; end
      if (got.sy !== w.sy) begin $error("scale_y exp %0d got %0d", w.sy, got.sy); errors++; end
      if (got.sz !== w.sz) begin $error("scale_z exp %0d got %0d", w.sz, got.sz); errors++; end
      if (got.sing !== w.sing) begin
        $error("singular exp %0d got %0d", w.sing, got.sing);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  logic signed [31:0] r_i [12];
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic done_o, singular_o;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [ANG_W-1:0] angle_x_o, angle_y_o, angle_z_o;
  logic [30:0] scale_x_o, scale_y_o, scale_z_o;

  pose_scoreboard board;
  longint cycles = 0;
  int burst_left = 0;

  initial foreach (r_i[k]) r_i[k] = '0;

  always #1 clk_i = ~clk_i;

  affine_matrix_decompose_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .r0c0_i(r_i[0]), .r0c1_i(r_i[1]), .r0c2_i(r_i[2]),
    .r1c0_i(r_i[3]), .r1c1_i(r_i[4]), .r1c2_i(r_i[5]),
    .r2c0_i(r_i[6]), .r2c1_i(r_i[7]), .r2c2_i(r_i[8]),
    .r3c0_i(r_i[9]), .r3c1_i(r_i[10]), .r3c2_i(r_i[11]),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .done_o(done_o), .pos_x_o(pos_x_o), .pos_y_o(pos_y_o), .pos_z_o(pos_z_o),
    .angle_x_o(angle_x_o), .angle_y_o(angle_y_o), .angle_z_o(angle_z_o),
    .scale_x_o(scale_x_o), .scale_y_o(scale_y_o), .scale_z_o(scale_z_o),
    .singular_o(singular_o));

  always @(posedge clk_i) begin
    pose_t got;
    cycles++;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
    if (rst_ni && done_o) begin
      got.px = pos_x_o; got.py = pos_y_o; got.pz = pos_z_o;
      got.ax = angle_x_o; got.ay = angle_y_o; got.az = angle_z_o;
      got.sx = scale_x_o; got.sy = scale_y_o; got.sz = scale_z_o;
      got.sing = singular_o;
      board.check_pose(got);
    end
  end

  task automatic write_limit(logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.limit = v;
  endtask

  // The sender may idle between bursts; the beat is taken when busy is low.
  task automatic send_matrix(mat_t e);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    start <= 1'b1;
    foreach (r_i[k]) r_i[k] <= e[k];
    do @(posedge clk_i); while (busy);
    board.note_matrix(e);
  endtask

  task automatic drain;
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_entry(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 131072)) - 65536;
      2: return $signed(32'($urandom_range(0, 8))) - 4;
      default: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
    endcase
  endfunction

  task automatic random_matrices(int n);
    mat_t e;
    int mode;
    repeat (n) begin
      mode = $urandom_range(0, 9);
      foreach (e[k]) e[k] = pick_entry(mode < 4 ? 0 : mode < 8 ? 1 : mode < 9 ? 2 : 3);
      if ($urandom_range(0, 5) == 0) begin
        e[0] = $signed(32'($urandom_range(0, 6))) - 3;
        e[3] = $signed(32'($urandom_range(0, 6))) - 3;
      end
      if ($urandom_range(0, 7) == 0) e[$urandom_range(0, 8)] = '0;
      send_matrix(e);
    end
  endtask

  initial begin
    mat_t e;
    logic signed [31:0] vals [6] = '{32'sh80000000, 32'sh7FFFFFFF, 0, -1, 1, 32'sh10000};
    board = new();
    board.limit = 16'd1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (vals[a]) begin
      foreach (e[k]) e[k] = vals[(a + k) % 6];
      send_matrix(e);
      foreach (e[k]) e[k] = vals[a];
      send_matrix(e);
    end
    foreach (e[k]) e[k] = '0;
    e[4] = 32'sh10000; e[5] = -32'sh10000; e[6] = -32'sh10000;
    send_matrix(e);
    e[8] = -32'sh10000; e[7] = 0; e[0] = -32'sh10000;
    send_matrix(e);
    e[3] = 32'sh7FFFFFFF; e[0] = 32'sh80000000;
    send_matrix(e);
    drain();

    write_limit(16'd0);
    random_matrices(200);
    drain();
    write_limit(16'hFFFF);
    random_matrices(250);
    drain();
    write_limit(16'($urandom_range(2, 65534)));
    random_matrices(250);
    drain();
    write_limit(16'd1);
    random_matrices(300);
    drain();

    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
